// ===== rtl/assert_macros.svh =====
// Assertion macros used by deadline_task_table_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Types and constants of the deadline task table.
// ----------------------------------------------------------------------------
`default_nettype none
package dtt_pkg;
  localparam int Slots = 16;
  localparam int SlotW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);

  typedef enum logic [2:0] {
    KIND_SCHED = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_RESCHED = 3'd2,
    KIND_TICK = 3'd3,
    KIND_POLL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] data;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_tag;
    logic [31:0] client_data;
    logic [31:0] delay;
    logic [7:0]  slot;
  } req_t;

  typedef struct packed {
    logic [7:0]  token;
    logic        removed_ok;
    logic        fired;
    logic [7:0]  fired_slot;
    logic [15:0] fired_tag;
    logic [31:0] fired_data;
  } rsp_t;

  // Scan information accumulated by the scanner as the ring passes its head.
  typedef struct packed {
    logic             have_free;
    logic [SlotW-1:0] free_idx;
    logic             have_best;
    logic [SlotW-1:0] best_idx;
    logic [31:0]      best_time;
  } scan_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic       shift;
    logic       wr;
    logic       clr;
    logic [SlotW-1:0] target;
    entry_t     wdata;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/dtt_if.sv =====
// ----------------------------------------------------------------------------
// dtt_if
// Valid/ready channel carrying one payload item.
// Valid/ready channels for requests and responses, one payload item each.
`default_nettype none
interface dtt_req_if;
  logic valid;
  logic ready;
  logic [2:0]  kind;
  logic [15:0] task_tag;
  logic [31:0] client_data;
  logic [31:0] delay;
  logic [7:0]  slot;
  modport source (output valid, kind, task_tag, client_data, delay, slot, input ready);
  modport sink (input valid, kind, task_tag, client_data, delay, slot, output ready);
endinterface

interface dtt_rsp_if;
  logic valid;
  logic ready;
  logic [7:0]  token;
  logic        removed_ok;
  logic        fired;
  logic [7:0]  fired_slot;
  logic [15:0] fired_tag;
  logic [31:0] fired_data;
  modport source (output valid, token, removed_ok, fired, fired_slot, fired_tag,
                  fired_data, input ready);
  modport sink (input valid, token, removed_ok, fired, fired_slot, fired_tag,
                fired_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/deadline_task_table_top.sv =====
// ----------------------------------------------------------------------------
// deadline_task_table_top
// Table of delayed tasks with a tick counter, held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req      in   kind, task_tag, client_data, delay, slot
// rsp      out  token, removed_ok, fired, fired_slot, fired_tag, fired_data
//
// Schedule and poll scan the table: the ring rotates once past the
// scanner, one entry a cycle. Other kinds go from idle straight to done.
// Reset is synchronous; the ring clears at the reset clock edge and an item may follow.
// One item is in work at a time; a held result stalls the next item only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module deadline_task_table_top (
  input wire logic  clk,
  input wire logic  rst,
  dtt_req_if.sink   req,
  dtt_rsp_if.source rsp
);
  localparam int SlotW = dtt_pkg::SlotW;

  dtt_pkg::state_t state, state_next;
  dtt_pkg::req_t   cur;
  logic [31:0]     now_ticks;
  logic [dtt_pkg::CntW-1:0] cnt;
  dtt_pkg::rsp_t   out_q;
  logic            out_valid;
  dtt_pkg::cell_ctl_t ctl;
  dtt_pkg::entry_t ring [dtt_pkg::Slots];
  dtt_pkg::scan_t  sres;
  logic            take, scanning, finish;
  logic [SlotW-1:0] head_idx;
  logic            in_range;

  assign take = req.valid && req.ready;
  assign scanning = (state == dtt_pkg::ST_SCAN);
  assign in_range = cur.slot < 8'(dtt_pkg::Slots);
  // Entry home index sitting at ring position 0 after cnt shifts.
  assign head_idx = SlotW'(cnt);

  // Cells: position k takes from position k+1, so the head sees slots in order.
  for (genvar k = 0; k < dtt_pkg::Slots; k++) begin : g_cell
    dtt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .home(SlotW'(k)),
      .prev(ring[(k + 1) % dtt_pkg::Slots]),
      .ent (ring[k])
    );
  end

  dtt_scan u_scan (
    .clk  (clk),
    .start(cnt == '0),
    .step (scanning),
    .idx  (head_idx),
    .head (ring[0]),
    .res  (sres)
  );

  always_comb begin
    state_next = state;
    case (state)
      dtt_pkg::ST_IDLE: begin
        if (take) begin
          state_next = (req.kind == dtt_pkg::KIND_SCHED || req.kind == dtt_pkg::KIND_POLL)
                       ? dtt_pkg::ST_SCAN : dtt_pkg::ST_DONE;
        end
      end
      dtt_pkg::ST_SCAN: begin
        if (cnt == dtt_pkg::CntW'(dtt_pkg::Slots - 1)) state_next = dtt_pkg::ST_DONE;
      end
      dtt_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) state_next = dtt_pkg::ST_IDLE;
      end
      default: state_next = dtt_pkg::ST_IDLE;
    endcase
  end

  assign finish = (state == dtt_pkg::ST_DONE) && (!out_valid || rsp.ready);
  assign req.ready = (state == dtt_pkg::ST_IDLE);

  // Cell control and the result of the finishing item.
  dtt_pkg::rsp_t rnext;
  logic due;
  assign due = sres.have_best && now_ticks >= sres.best_time;
  always_comb begin
    ctl = '0;
    ctl.shift = scanning;
    ctl.wdata.tag = cur.task_tag;
    ctl.wdata.data = cur.client_data;
    ctl.wdata.deadline = now_ticks + cur.delay;
    rnext = '0;
    if (finish) begin
      case (cur.kind)
        dtt_pkg::KIND_SCHED: begin
          if (sres.have_free && cur.task_tag != '0) begin
            ctl.wr = 1'b1;
            ctl.target = sres.free_idx;
            rnext.token = 8'(sres.free_idx);
          end
        end
        dtt_pkg::KIND_REMOVE: begin
          ctl.target = cur.slot[SlotW-1:0];
          if (in_range && ring[cur.slot[SlotW-1:0]].tag != '0) begin
            ctl.clr = 1'b1;
            rnext.removed_ok = 1'b1;
          end
        end
        dtt_pkg::KIND_RESCHED: begin
          ctl.target = cur.slot[SlotW-1:0];
          ctl.wr = in_range;
        end
        dtt_pkg::KIND_POLL: begin
          ctl.target = sres.best_idx;
          if (due) begin
            ctl.clr = 1'b1;
            rnext.fired = 1'b1;
            rnext.fired_slot = 8'(sres.best_idx);
            rnext.fired_tag = ring[sres.best_idx].tag;
            rnext.fired_data = ring[sres.best_idx].data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtt_pkg::ST_IDLE;
      now_ticks <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) cnt <= '0;
      else if (scanning) cnt <= cnt + 1'b1;
      if (finish && cur.kind == dtt_pkg::KIND_TICK) now_ticks <= now_ticks + 32'd1;
      if (finish) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= {req.kind, req.task_tag, req.client_data, req.delay, req.slot};
    end
    if (finish) out_q <= rnext;
  end

  assign rsp.valid = out_valid;
  assign rsp.token = out_q.token;
  assign rsp.removed_ok = out_q.removed_ok;
  assign rsp.fired = out_q.fired;
  assign rsp.fired_slot = out_q.fired_slot;
  assign rsp.fired_tag = out_q.fired_tag;
  assign rsp.fired_data = out_q.fired_data;

  `CHK_IMPL(a_no_take_busy, clk, rst, state != dtt_pkg::ST_IDLE, !take, "item taken while busy")
  `CHK_NEXT(a_finish_valid, clk, rst, finish, rsp.valid, "result lost")
  `CHK_IMPL(a_cnt_idle, clk, rst, scanning, cnt < dtt_pkg::CntW'(dtt_pkg::Slots), "scan overrun")
endmodule
`default_nettype wire

// ===== rtl/dtt_cell.sv =====
// ----------------------------------------------------------------------------
// dtt_cell
// One slot of the ring: holds an entry, rotates it to its neighbour on shift.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dtt_pkg::cell_ctl_t ctl,
  input  wire logic [dtt_pkg::SlotW-1:0] home,
  input  wire dtt_pkg::entry_t    prev,
  output dtt_pkg::entry_t         ent
);
  // Entries rotate one place per shift; after Slots shifts each is home again.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctl.shift) begin
      ent <= prev;
    end else if (ctl.clr && ctl.target == home) begin
      ent <= '0;
    end else if (ctl.wr && ctl.target == home) begin
      ent <= ctl.wdata;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dtt_scan.sv =====
// ----------------------------------------------------------------------------
// dtt_scan
// Serial scanner: looks at the entry passing the ring head, one per cycle while step is high; index 0 is skipped.
// ----------------------------------------------------------------------------
`default_nettype none
module dtt_scan (
  input  wire logic                      clk,
  input  wire logic                      start,
  input  wire logic                      step,
  input  wire logic [dtt_pkg::SlotW-1:0] idx,
  input  wire dtt_pkg::entry_t           head,
  output dtt_pkg::scan_t                 res
);
  dtt_pkg::scan_t cur;
  dtt_pkg::scan_t res_next;

  assign cur = start ? '0 : res;

  always_comb begin
    res_next = cur;
    if (idx != '0) begin
      if (!cur.have_free && head.tag == '0) begin
        res_next.have_free = 1'b1;
        res_next.free_idx = idx;
      end
      if (head.tag != '0 && (!cur.have_best || head.deadline < cur.best_time)) begin
        res_next.have_best = 1'b1;
        res_next.best_idx = idx;
        res_next.best_time = head.deadline;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end
endmodule
`default_nettype wire
